// File: rtl/scf_pkg.sv
package scf_pkg;

  // Compare condition codes
  typedef enum logic [3:0] {
    COND_UNCOND   = 4'd0,
    COND_EQ       = 4'd1,
    COND_INC      = 4'd2,
    COND_DEC      = 4'd3,
    COND_INC_BY   = 4'd4,
    COND_DEC_BY   = 4'd5,
    COND_NE_PREV  = 4'd6,
    COND_EQ_PREV  = 4'd7,
    COND_GT       = 4'd8,
    COND_LT       = 4'd9
  } cond_t;

  // Configuration register indexes
  localparam logic [1:0] CFG_CONDITION     = 2'd0;
  localparam logic [1:0] CFG_COMPARE_VALUE = 2'd1;
  localparam logic [1:0] CFG_ELEMENT_BYTES = 2'd2;

  localparam logic [14:0] COUNT_MAX = 15'h7fff;
  localparam logic [31:0] BYTE_MASK = 32'h0000_00ff;
  localparam logic [31:0] HALF_MASK = 32'h0000_ffff;

  // Classified element as it travels from front to back
  typedef struct packed {
    logic        pass_start;
    logic        in_range;
    logic [11:0] idx;
    logic [31:0] value;
    logic [2:0]  nbytes;
  } item_t;

  // One result transfer
  typedef struct packed {
    logic        matched;
    logic        still_candidate;
    logic [14:0] match_count;
  } result_t;

  // Value mask for a normalized element size (1, 2 or 4 bytes)
  function automatic logic [31:0] size_mask(input logic [2:0] nbytes);
    logic [31:0] m;
    begin
      m = '1;
      if (nbytes == 3'd1) begin
        m = BYTE_MASK;
      end else if (nbytes == 3'd2) begin
        m = HALF_MASK;
      end
      return m;
    end
  endfunction

endpackage

// File: rtl/scf_front.sv
module scf_front #(
  parameter int REGION_ELEMENTS = 4096
) (
  input  logic          in_valid,
  output logic          in_ready,
  input  logic          in_pass_start,
  input  logic [11:0]   in_element_index,
  input  logic [31:0]   in_current_value,
  input  logic [2:0]    element_bytes,
  input  logic          clearing,
  output logic          push_valid,
  input  logic          push_ready,
  output scf_pkg::item_t push_item
);
  import scf_pkg::*;

  logic [2:0] nbytes;

  // Hold input off during the post-reset clearing sweep
  assign in_ready   = push_ready && !clearing;
  assign push_valid = in_valid && !clearing;

  // Normalize size: 1 or 2 bytes as given, anything else is a word
  always_comb begin
    case (element_bytes)
      3'd1:    nbytes = 3'd1;
      3'd2:    nbytes = 3'd2;
      default: nbytes = 3'd4;
    endcase
  end

  // Classify: mask value, check index against region size
  always_comb begin
    push_item.pass_start = in_pass_start;
    push_item.in_range   = ({20'd0, in_element_index} < 32'(REGION_ELEMENTS));
    push_item.idx        = in_element_index;
    push_item.value      = in_current_value & size_mask(nbytes);
    push_item.nbytes     = nbytes;
  end

endmodule

// File: rtl/scf_queue.sv
module scf_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push_valid,
  output logic           push_ready,
  input  scf_pkg::item_t push_item,
  output logic           pop_valid,
  input  logic           pop_ready,
  output scf_pkg::item_t pop_item
);
  import scf_pkg::*;

  item_t      store_r [2];
  logic       wr_ptr_r;
  logic       rd_ptr_r;
  logic [1:0] count_r;
  logic       push;
  logic       pop;

  assign push_ready = (count_r != 2'd2);
  assign pop_valid  = (count_r != 2'd0);
  assign pop_item   = store_r[rd_ptr_r];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  // Pointers and fill level
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (push) wr_ptr_r <= ~wr_ptr_r;
      if (pop)  rd_ptr_r <= ~rd_ptr_r;
      count_r <= count_r + {1'b0, push} - {1'b0, pop};
    end
  end

  // Entry storage
  always_ff @(posedge clk) begin
    if (push) store_r[wr_ptr_r] <= push_item;
  end

endmodule

// File: rtl/scf_back.sv
module scf_back #(
  parameter int REGION_ELEMENTS = 4096
) (
  input  logic             clk,
  input  logic             rst_n,
  input  scf_pkg::cond_t   condition,
  input  logic [31:0]      compare_value,
  input  logic             q_valid,
  output logic             q_ready,
  input  scf_pkg::item_t   q_item,
  output logic             clearing,
  output logic             res_valid,
  input  logic             res_ready,
  output scf_pkg::result_t res_data
);
  import scf_pkg::*;

  localparam int AW = $clog2(REGION_ELEMENTS);
  localparam int XW = (AW > 12) ? AW : 12;
  localparam int RESET_BYTES = REGION_ELEMENTS * 4;
  localparam logic [14:0] COUNT_RESET =
    (RESET_BYTES > 32767) ? COUNT_MAX : 15'(RESET_BYTES);
  localparam logic [AW-1:0] LAST_ADDR = AW'(REGION_ELEMENTS - 1);

  // Element stores
  logic [31:0] snap_mem [REGION_ELEMENTS];
  logic        cand_mem [REGION_ELEMENTS];

  // Clearing sweep
  logic          clearing_r;
  logic [AW-1:0] clr_addr_r;

  // Execute stage
  logic        b_valid_r;
  item_t       b_item_r;
  logic [31:0] snap_rd_r;
  logic        cand_rd_r;

  // Pass state
  logic [14:0] pass_count_r;
  logic        pass_active_r;

  // Output register
  logic    out_valid_r;
  result_t out_res_r;

  logic          pop;
  logic          b_fire;
  logic [XW-1:0] rd_ext;
  logic [XW-1:0] wr_ext;
  logic [AW-1:0] rd_addr;
  logic [AW-1:0] wr_addr;

  logic [31:0] mask;
  logic [31:0] cur;
  logic [31:0] prev;
  logic [31:0] prev_plus;
  logic [31:0] prev_minus;
  logic        test_pass;
  logic        active_nxt;
  logic [14:0] count_base;
  logic [2:0]  count_inc;
  logic [15:0] count_sum;
  logic [14:0] count_nxt;
  logic        hit;
  logic        cand_new;
  logic        still;
  logic        upd;
  logic        snap_we;
  logic        cand_we;
  logic [AW-1:0] cand_waddr;
  logic        cand_wdata;

  assign clearing  = clearing_r;
  assign res_valid = out_valid_r;
  assign res_data  = out_res_r;

  // Handshake between queue, execute stage and output register
  assign b_fire  = b_valid_r && (!out_valid_r || res_ready);
  assign q_ready = (!b_valid_r || b_fire) && !clearing_r;
  assign pop     = q_valid && q_ready;

  assign rd_ext  = XW'(q_item.idx);
  assign wr_ext  = XW'(b_item_r.idx);
  assign rd_addr = rd_ext[AW-1:0];
  assign wr_addr = wr_ext[AW-1:0];

  // Operands
  assign mask       = size_mask(b_item_r.nbytes);
  assign cur        = b_item_r.value;
  assign prev       = snap_rd_r & mask;
  assign prev_plus  = prev + compare_value;
  assign prev_minus = prev - compare_value;

  // Selected test
  always_comb begin
    case (condition)
      COND_EQ:       test_pass = (cur == compare_value);
      COND_INC:      test_pass = (cur > prev);
      COND_DEC:      test_pass = (cur < prev);
      COND_INC_BY:   test_pass = (cur == prev_plus);
      COND_DEC_BY:   test_pass = (cur == prev_minus);
      COND_NE_PREV:  test_pass = (cur != prev);
      COND_EQ_PREV:  test_pass = (cur == prev);
      COND_GT:       test_pass = ($signed(compare_value) < $signed(cur));
      COND_LT:       test_pass = ($signed(cur) < $signed(compare_value));
      default:       test_pass = 1'b0;
    endcase
  end

  // Pass bookkeeping and candidate update
  always_comb begin
    if (b_item_r.pass_start) begin
      active_nxt = (pass_count_r != 15'd0);
      count_base = (pass_count_r != 15'd0) ? 15'd0 : pass_count_r;
    end else begin
      active_nxt = pass_active_r;
      count_base = pass_count_r;
    end
    upd       = b_item_r.in_range && active_nxt;
    hit       = 1'b0;
    cand_new  = cand_rd_r;
    count_inc = 3'd0;
    if (upd) begin
      if (condition == COND_UNCOND) begin
        cand_new  = 1'b1;
        hit       = 1'b1;
        count_inc = b_item_r.nbytes;
      end else if (cand_rd_r) begin
        if (test_pass) begin
          hit       = 1'b1;
          count_inc = 3'd1;
        end else begin
          cand_new = 1'b0;
        end
      end
    end
    count_sum = {1'b0, count_base} + {13'd0, count_inc};
    count_nxt = (count_sum > {1'b0, COUNT_MAX}) ? COUNT_MAX : count_sum[14:0];
    still     = b_item_r.in_range && cand_new;
  end

  assign snap_we    = b_fire && upd;
  assign cand_we    = clearing_r || (b_fire && upd);
  assign cand_waddr = clearing_r ? clr_addr_r : wr_addr;
  assign cand_wdata = clearing_r || cand_new;

  // Snapshot store, write-first bypass for back-to-back same index
  always_ff @(posedge clk) begin
    if (snap_we) snap_mem[wr_addr] <= cur;
    if (pop) begin
      snap_rd_r <= (snap_we && (wr_addr == rd_addr)) ? cur : snap_mem[rd_addr];
    end
  end

  // Candidate store, same bypass
  always_ff @(posedge clk) begin
    if (cand_we) cand_mem[cand_waddr] <= cand_wdata;
    if (pop) begin
      cand_rd_r <= (cand_we && (cand_waddr == rd_addr)) ? cand_wdata : cand_mem[rd_addr];
    end
  end

  // Post-reset sweep sets every candidate bit
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clearing_r <= 1'b1;
      clr_addr_r <= '0;
    end else if (clearing_r) begin
      clr_addr_r <= clr_addr_r + 1'b1;
      if (clr_addr_r == LAST_ADDR) clearing_r <= 1'b0;
    end
  end

  // Execute stage control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_valid_r <= 1'b0;
    end else if (pop) begin
      b_valid_r <= 1'b1;
    end else if (b_fire) begin
      b_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) b_item_r <= q_item;
  end

  // Pass state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pass_count_r  <= COUNT_RESET;
      pass_active_r <= 1'b1;
    end else if (b_fire) begin
      pass_count_r  <= count_nxt;
      pass_active_r <= active_nxt;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (b_fire) begin
      out_valid_r <= 1'b1;
    end else if (res_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (b_fire) begin
      out_res_r.matched         <= hit;
      out_res_r.still_candidate <= still;
      out_res_r.match_count     <= count_nxt;
    end
  end

`ifndef SYNTH
  // No element enters execution while the candidate sweep runs
  a_no_pop_clearing: assert property (@(posedge clk) disable iff (!rst_n)
    clearing_r |-> !pop)
    else $error("element popped during clearing sweep");

  // Count only grows within a pass
  a_count_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
    (b_fire && !b_item_r.pass_start) |-> (count_nxt >= pass_count_r))
    else $error("match count dropped inside a pass");

  // A match always leaves the element a candidate
  a_match_is_cand: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (!out_res_r.matched || out_res_r.still_candidate))
    else $error("match reported on a removed candidate");

  // A stalled execute stage keeps its element
  a_stage_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (b_valid_r && !b_fire) |=> (b_valid_r && $stable(b_item_r)))
    else $error("execute stage lost a stalled element");
`endif

endmodule

// File: rtl/snapshot_compare_filter.sv
// Path from input transfer to result valid: queue, execute stage, output register.
// Throughput: one element per cycle unless out_ready stalls the output; the single
// snapshot/candidate read-modify-write per element sets the rate, with a write-first bypass for repeated indexes.
// Reset (rst_n low, synchronous) clears control state; afterwards a sweep over all
// REGION_ELEMENTS addresses sets every candidate bit and in_ready stays low meanwhile.
// Configuration writes are taken at any time, including during the sweep.
module snapshot_compare_filter #(
  parameter int REGION_ELEMENTS = 4096
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_wdata,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_pass_start,
  input  logic [11:0] in_element_index,
  input  logic [31:0] in_current_value,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_matched,
  output logic        out_still_candidate,
  output logic [14:0] out_match_count
);
  import scf_pkg::*;

  cond_t       condition_r;
  logic [31:0] compare_value_r;
  logic [2:0]  element_bytes_r;

  logic    clearing;
  logic    push_valid;
  logic    push_ready;
  item_t   push_item;
  logic    pop_valid;
  logic    pop_ready;
  item_t   pop_item;
  result_t res_data;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      condition_r     <= COND_UNCOND;
      compare_value_r <= 32'd0;
      element_bytes_r <= 3'd4;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_CONDITION:     condition_r     <= cond_t'(cfg_wdata[3:0]);
        CFG_COMPARE_VALUE: compare_value_r <= cfg_wdata;
        CFG_ELEMENT_BYTES: element_bytes_r <= cfg_wdata[2:0];
        default: ;
      endcase
    end
  end

  scf_front #(
    .REGION_ELEMENTS (REGION_ELEMENTS)
  ) u_front (
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_pass_start    (in_pass_start),
    .in_element_index (in_element_index),
    .in_current_value (in_current_value),
    .element_bytes    (element_bytes_r),
    .clearing         (clearing),
    .push_valid       (push_valid),
    .push_ready       (push_ready),
    .push_item        (push_item)
  );

  scf_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_item  (push_item),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_item   (pop_item)
  );

  scf_back #(
    .REGION_ELEMENTS (REGION_ELEMENTS)
  ) u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .condition     (condition_r),
    .compare_value (compare_value_r),
    .q_valid       (pop_valid),
    .q_ready       (pop_ready),
    .q_item        (pop_item),
    .clearing      (clearing),
    .res_valid     (out_valid),
    .res_ready     (out_ready),
    .res_data      (res_data)
  );

  assign out_matched         = res_data.matched;
  assign out_still_candidate = res_data.still_candidate;
  assign out_match_count     = res_data.match_count;

endmodule
